/* rtl/gcfd_pkg.sv */
// Shared types and constants for the ground current fault detector.
`timescale 1ns / 1ps

package gcfd_pkg;

   // Fixed field widths and the gain scaling of the low-pass filters.
   localparam int unsigned FIELD_BITS = 16;
   localparam int unsigned GAIN_BITS  = 16;
   localparam int unsigned GAIN_SHIFT = 16;
   localparam int unsigned MAG_BITS   = 16;
   localparam logic [MAG_BITS-1:0] MAG_MAX = 16'hFFFF;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_COMPONENT_GAIN  = 2'd0,
      CSR_MAGNITUDE_GAIN  = 2'd1,
      CSR_FAULT_THRESHOLD = 2'd2,
      CSR_ALARM_THRESHOLD = 2'd3
   } csr_index_type;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET      = 16'd655;
   localparam logic [MAG_BITS-1:0]  THRESHOLD_RESET = 16'hFFFF;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XMUL,
      ST_XADD,
      ST_YMUL,
      ST_YADD,
      ST_SQMUL,
      ST_SQADD,
      ST_ROOT,
      ST_MMUL,
      ST_MADD,
      ST_OUT
   } state_type;

   // Request payload.
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] current_x;
      logic signed [FIELD_BITS-1:0] current_y;
      logic                         bridge_enabled;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [MAG_BITS-1:0] magnitude_raw;
      logic [MAG_BITS-1:0] magnitude_filtered;
      logic                fault;
      logic                alarm;
   } rsp_type;

endpackage

/* rtl/ground_current_fault_detector.sv */
// Top level of the ground current fault detector: sequencer and shared multiplier datapath.
`timescale 1ns / 1ps

// Usage:
// One request carries an X/Y ground current sample and the bridge-enable bit; it
// produces exactly one response with the raw magnitude of the filtered vector, the
// low-passed magnitude and the fault and alarm flags.
// req_ready is high only while the sequencer is idle. An enabled request runs
// through one shared multiplier (X filter, Y filter, the squares in 16-bit chunks,
// the magnitude filter) and a square root that resolves one bit per cycle.
// Each square is built from ceil(AW/16) chunks and the root has AW bits, where
// AW = min(SAMPLE_BITS + FRAC_BITS, 32). The next request can be taken in the same
// cycle as the response turns valid. A request with the bridge disabled clears
// all filters and goes straight to the output state for an all-zero response.
// The response sits in an output register: while the receiver stalls the block
// still accepts and works on the next request, and holds that result back until
// the output register frees.
// Reset clears the filters and loads the register defaults (gains 655, thresholds
// 65535). Write csr_ port registers only while idle; the block does not enforce it.
module ground_current_fault_detector #(
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  gcfd_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output gcfd_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [gcfd_pkg::GAIN_BITS-1:0]        csr_wdata
);

   // Derived widths.
   localparam int unsigned SW     = SAMPLE_BITS + FRAC_BITS;
   localparam int unsigned EXCESS = (SW > 32) ? (SW - 32) : 0;
   localparam int unsigned AW     = SW - EXCESS;
   localparam int unsigned SQW    = 2 * AW;
   localparam int unsigned NCH    = (AW + 15) / 16;
   localparam int unsigned CIW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int unsigned RCW    = $clog2(AW);
   localparam int unsigned RSH    = FRAC_BITS - EXCESS;
   localparam int unsigned MW     = gcfd_pkg::MAG_BITS + FRAC_BITS;
   localparam int unsigned MA     = (SW > MW) ? (SW + 1) : (MW + 1);
   localparam int unsigned PW     = MA + gcfd_pkg::GAIN_BITS + 1;
   localparam int unsigned FW     = (SAMPLE_BITS > gcfd_pkg::FIELD_BITS) ?
                                    SAMPLE_BITS : gcfd_pkg::FIELD_BITS;
   localparam int unsigned GAIN_SHIFT_L = gcfd_pkg::GAIN_SHIFT;

   // Configuration registers.
   logic [gcfd_pkg::GAIN_BITS-1:0] comp_gain_ff, comp_gain_in;
   logic [gcfd_pkg::GAIN_BITS-1:0] mag_gain_ff, mag_gain_in;
   logic [gcfd_pkg::MAG_BITS-1:0]  fault_thr_ff, fault_thr_in;
   logic [gcfd_pkg::MAG_BITS-1:0]  alarm_thr_ff, alarm_thr_in;

   // Sequencer and datapath registers.
   gcfd_pkg::state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0] samp_x_ff, samp_x_in;
   logic [SAMPLE_BITS-1:0] samp_y_ff, samp_y_in;
   logic                   en_ff, en_in;
   logic [SW-1:0]          x_ff, x_in;
   logic [SW-1:0]          y_ff, y_in;
   logic [MW-1:0]          mag_ff, mag_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic [AW:0]            rem_ff, rem_in;
   logic [AW-1:0]          root_ff, root_in;
   logic [RCW-1:0]         root_cnt_ff, root_cnt_in;
   logic                   sq_y_ff, sq_y_in;
   logic [CIW-1:0]         chunk_ff, chunk_in;
   logic signed [PW-1:0]   prod_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   gcfd_pkg::rsp_type      rsp_ff, rsp_in;

   // Control decodes.
   logic                   accept;
   logic                   rsp_load;
   logic                   chunk_last;
   logic                   sq_last;
   logic                   root_last;

   // Datapath combinational values.
   logic [FW-1:0]                  fx_ext, fy_ext;
   logic [SW-1:0]                  tx, ty;
   logic signed [SW:0]             dx, dy;
   logic [SW-1:0]                  ax_full, ay_full, ax_sh, ay_sh;
   logic [AW-1:0]                  ax, ay, sq_op;
   logic [16*NCH-1:0]              sq_op_ext;
   logic [AW-1:0]                  root_sh;
   logic [gcfd_pkg::MAG_BITS-1:0]  raw16;
   logic [MW-1:0]                  tm;
   logic signed [MW:0]             dm;
   logic signed [MA-1:0]           mul_a;
   logic [gcfd_pkg::GAIN_BITS-1:0] mul_b;
   logic signed [PW-1:0]           prod;
   logic [SQW-1:0]                 sq_part;
   logic [AW+2:0]                  rem_sh, trial, rem_diff;
   logic [gcfd_pkg::MAG_BITS-1:0]  filt;

   // Configuration writes.
   always_comb begin
      comp_gain_in = comp_gain_ff;
      mag_gain_in  = mag_gain_ff;
      fault_thr_in = fault_thr_ff;
      alarm_thr_in = alarm_thr_ff;
      if (csr_we) begin
         case (gcfd_pkg::csr_index_type'(csr_index))
            gcfd_pkg::CSR_COMPONENT_GAIN:  comp_gain_in = csr_wdata;
            gcfd_pkg::CSR_MAGNITUDE_GAIN:  mag_gain_in  = csr_wdata;
            gcfd_pkg::CSR_FAULT_THRESHOLD: fault_thr_in = csr_wdata;
            gcfd_pkg::CSR_ALARM_THRESHOLD: alarm_thr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Loop end conditions.
   assign chunk_last = (chunk_ff == CIW'(NCH - 1));
   assign sq_last    = sq_y_ff && chunk_last;
   assign root_last  = (root_cnt_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcfd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_data.bridge_enabled ? gcfd_pkg::ST_XMUL : gcfd_pkg::ST_OUT;
            end
         end
         gcfd_pkg::ST_XMUL:  state_in = gcfd_pkg::ST_XADD;
         gcfd_pkg::ST_XADD:  state_in = gcfd_pkg::ST_YMUL;
         gcfd_pkg::ST_YMUL:  state_in = gcfd_pkg::ST_YADD;
         gcfd_pkg::ST_YADD:  state_in = gcfd_pkg::ST_SQMUL;
         gcfd_pkg::ST_SQMUL: state_in = gcfd_pkg::ST_SQADD;
         gcfd_pkg::ST_SQADD: begin
            state_in = sq_last ? gcfd_pkg::ST_ROOT : gcfd_pkg::ST_SQMUL;
         end
         gcfd_pkg::ST_ROOT: begin
            if (root_last) begin
               state_in = gcfd_pkg::ST_MMUL;
            end
         end
         gcfd_pkg::ST_MMUL:  state_in = gcfd_pkg::ST_MADD;
         gcfd_pkg::ST_MADD:  state_in = gcfd_pkg::ST_OUT;
         gcfd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = gcfd_pkg::ST_IDLE;
            end
         end
         default: state_in = gcfd_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and multiplier operand selection.
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         gcfd_pkg::ST_IDLE: req_ready = 1'b1;
         gcfd_pkg::ST_XMUL: begin
            mul_a = MA'(dx);
            mul_b = comp_gain_ff;
         end
         gcfd_pkg::ST_YMUL: begin
            mul_a = MA'(dy);
            mul_b = comp_gain_ff;
         end
         gcfd_pkg::ST_SQMUL: begin
            mul_a = MA'(sq_op);
            mul_b = sq_op_ext[chunk_ff*16 +: 16];
         end
         gcfd_pkg::ST_MMUL: begin
            mul_a = MA'(dm);
            mul_b = mag_gain_ff;
         end
         gcfd_pkg::ST_OUT: rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   // Filter targets and differences: sample scaled by 2^FRAC_BITS minus the state.
   assign fx_ext = FW'(req_data.current_x);
   assign fy_ext = FW'(req_data.current_y);
   assign tx     = {samp_x_ff, {FRAC_BITS{1'b0}}};
   assign ty     = {samp_y_ff, {FRAC_BITS{1'b0}}};
   assign dx     = $signed({tx[SW-1], tx}) - $signed({x_ff[SW-1], x_ff});
   assign dy     = $signed({ty[SW-1], ty}) - $signed({y_ff[SW-1], y_ff});

   // Absolute values of the filtered components, trimmed so the squares fit.
   assign ax_full   = x_ff[SW-1] ? (~x_ff + SW'(1)) : x_ff;
   assign ay_full   = y_ff[SW-1] ? (~y_ff + SW'(1)) : y_ff;
   assign ax_sh     = ax_full >> EXCESS;
   assign ay_sh     = ay_full >> EXCESS;
   assign ax        = ax_sh[AW-1:0];
   assign ay        = ay_sh[AW-1:0];
   assign sq_op     = sq_y_ff ? ay : ax;
   assign sq_op_ext = (16*NCH)'(sq_op);

   // Shared multiplier: signed operand times an unsigned 16-bit factor.
   assign prod    = mul_a * $signed({1'b0, mul_b});
   assign sq_part = SQW'(prod_ff[AW+15:0]) << {chunk_ff, 4'b0000};

   // One square root bit per cycle, taking radicand bits from the top of sq_ff.
   assign rem_sh   = {rem_ff, sq_ff[SQW-1 -: 2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign rem_diff = rem_sh - trial;

   // Integer part of the root, saturated, and the magnitude filter difference.
   assign root_sh = root_ff >> RSH;
   assign raw16   = (root_sh > AW'(gcfd_pkg::MAG_MAX)) ? gcfd_pkg::MAG_MAX :
                    root_sh[gcfd_pkg::MAG_BITS-1:0];
   assign tm      = {raw16, {FRAC_BITS{1'b0}}};
   assign dm      = $signed({1'b0, tm}) - $signed({1'b0, mag_ff});
   assign filt    = mag_ff[FRAC_BITS +: gcfd_pkg::MAG_BITS];

   // Datapath register updates.
   always_comb begin
      samp_x_in   = samp_x_ff;
      samp_y_in   = samp_y_ff;
      en_in       = en_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      mag_in      = mag_ff;
      sq_in       = sq_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      root_cnt_in = root_cnt_ff;
      sq_y_in     = sq_y_ff;
      chunk_in    = chunk_ff;
      case (state_ff)
         gcfd_pkg::ST_IDLE: begin
            if (accept) begin
               samp_x_in = fx_ext[SAMPLE_BITS-1:0];
               samp_y_in = fy_ext[SAMPLE_BITS-1:0];
               en_in     = req_data.bridge_enabled;
               if (!req_data.bridge_enabled) begin
                  x_in   = '0;
                  y_in   = '0;
                  mag_in = '0;
               end
            end
         end
         gcfd_pkg::ST_XADD: x_in = x_ff + prod_ff[GAIN_SHIFT_L +: SW];
         gcfd_pkg::ST_YADD: begin
            y_in     = y_ff + prod_ff[GAIN_SHIFT_L +: SW];
            sq_in    = '0;
            sq_y_in  = 1'b0;
            chunk_in = '0;
         end
         gcfd_pkg::ST_SQADD: begin
            sq_in = sq_ff + sq_part;
            if (chunk_last) begin
               chunk_in = '0;
               sq_y_in  = 1'b1;
            end else begin
               chunk_in = chunk_ff + CIW'(1);
            end
            rem_in      = '0;
            root_in     = '0;
            root_cnt_in = RCW'(AW - 1);
         end
         gcfd_pkg::ST_ROOT: begin
            sq_in = sq_ff << 2;
            if (!rem_diff[AW+2]) begin
               rem_in  = rem_diff[AW:0];
               root_in = {root_ff[AW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[AW:0];
               root_in = {root_ff[AW-2:0], 1'b0};
            end
            root_cnt_in = root_cnt_ff - RCW'(1);
         end
         gcfd_pkg::ST_MADD: mag_in = mag_ff + prod_ff[GAIN_SHIFT_L +: MW];
         default: ;
      endcase
   end

   // Response register: all zero while the bridge is disabled.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (en_ff) begin
            rsp_in.magnitude_raw      = raw16;
            rsp_in.magnitude_filtered = filt;
            rsp_in.fault              = (filt >= fault_thr_ff);
            rsp_in.alarm              = (filt >= alarm_thr_ff);
         end else begin
            rsp_in = '0;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcfd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         comp_gain_ff <= gcfd_pkg::GAIN_RESET;
         mag_gain_ff  <= gcfd_pkg::GAIN_RESET;
         fault_thr_ff <= gcfd_pkg::THRESHOLD_RESET;
         alarm_thr_ff <= gcfd_pkg::THRESHOLD_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         mag_ff       <= '0;
         root_cnt_ff  <= '0;
         sq_y_ff      <= 1'b0;
         chunk_ff     <= '0;
         en_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         comp_gain_ff <= comp_gain_in;
         mag_gain_ff  <= mag_gain_in;
         fault_thr_ff <= fault_thr_in;
         alarm_thr_ff <= alarm_thr_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         mag_ff       <= mag_in;
         root_cnt_ff  <= root_cnt_in;
         sq_y_ff      <= sq_y_in;
         chunk_ff     <= chunk_in;
         en_ff        <= en_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      samp_x_ff <= samp_x_in;
      samp_y_ff <= samp_y_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      prod_ff   <= prod;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the ground current fault detector.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned SAMPLE_W      = 16;
   localparam int unsigned FRAC_W        = 16;
   localparam int unsigned PHASES        = 6;
   localparam int unsigned PHASE_ITEMS   = 192;
   localparam int unsigned SETTLE_CYCLES = 60;
   localparam int unsigned FINAL_WAIT    = 5000;
   localparam longint      ONE           = 64'sd1 <<< FRAC_W;

   typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_type;

   // One line of the directed table: either a register write or a request.
   typedef struct {
      row_kind_type            kind;
      gcfd_pkg::csr_index_type reg_index;
      logic [15:0]             reg_value;
      gcfd_pkg::req_type       req;
      logic                    has_fixed;
      gcfd_pkg::rsp_type       fixed_rsp;
   } stim_row_type;

   localparam gcfd_pkg::rsp_type ZERO_RSP  = '0;
   localparam gcfd_pkg::rsp_type FLAGS_RSP = '{magnitude_raw: 16'd0,
                                               magnitude_filtered: 16'd0,
                                               fault: 1'b1, alarm: 1'b1};

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   gcfd_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   gcfd_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // Expected responses, oldest first, and the error tally.
   gcfd_pkg::rsp_type expected_rsp_q[$];
   int unsigned error_count = 0;
   bit          sender_quiet = 1'b0;
   bit          receiver_quiet = 1'b0;

   // Shadow copy of the filter state and the registers.
   longint      x_state = 0;
   longint      y_state = 0;
   longint      mag_state = 0;
   logic [15:0] comp_gain_r = gcfd_pkg::GAIN_RESET;
   logic [15:0] mag_gain_r  = gcfd_pkg::GAIN_RESET;
   logic [15:0] fault_thr_r = gcfd_pkg::THRESHOLD_RESET;
   logic [15:0] alarm_thr_r = gcfd_pkg::THRESHOLD_RESET;

   stim_row_type directed_rows[$];

   ground_current_fault_detector #(
      .SAMPLE_BITS(SAMPLE_W),
      .FRAC_BITS  (FRAC_W)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // First-order low-pass step; the arithmetic shift floors toward minus infinity.
   function automatic longint lowpass_step(longint s, longint target, logic [15:0] gain);
      longint g;
      g = gain;
      return s + (((target - s) * g) >>> gcfd_pkg::GAIN_SHIFT);
   endfunction

   // Bitwise integer square root of a 64-bit value.
   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // Advances the shadow filters by one request and returns the response it yields.
   function automatic gcfd_pkg::rsp_type predict_tick(gcfd_pkg::req_type r);
      gcfd_pkg::rsp_type o;
      longint          xs;
      longint          ys;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned raw;
      longint unsigned filt;
      o = '0;
      if (!r.bridge_enabled) begin
         x_state = 0;
         y_state = 0;
         mag_state = 0;
         return o;
      end
      xs = r.current_x;
      ys = r.current_y;
      x_state = lowpass_step(x_state, xs * ONE, comp_gain_r);
      y_state = lowpass_step(y_state, ys * ONE, comp_gain_r);
      ax = (x_state < 0) ? -x_state : x_state;
      ay = (y_state < 0) ? -y_state : y_state;
      raw = root64(ax * ax + ay * ay) >> FRAC_W;
      if (raw > gcfd_pkg::MAG_MAX) raw = gcfd_pkg::MAG_MAX;
      mag_state = lowpass_step(mag_state, longint'(raw) * ONE, mag_gain_r);
      filt = mag_state;
      filt = filt >> FRAC_W;
      if (filt > gcfd_pkg::MAG_MAX) filt = gcfd_pkg::MAG_MAX;
      o.magnitude_raw      = raw[15:0];
      o.magnitude_filtered = filt[15:0];
      o.fault              = (filt >= fault_thr_r);
      o.alarm              = (filt >= alarm_thr_r);
      return o;
   endfunction

   task automatic note_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) note_error($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Gap length: mostly none or short, now and then long.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'($urandom_range(0, 511)) - 16'd256;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic stim_row_type write_row(gcfd_pkg::csr_index_type idx,
                                              logic [15:0] val);
      stim_row_type row;
      row = '{kind: ROW_WRITE, reg_index: idx, reg_value: val, req: '0,
              has_fixed: 1'b0, fixed_rsp: '0};
      return row;
   endfunction

   function automatic stim_row_type request_row(logic signed [15:0] x, logic signed [15:0] y,
                                                logic en, logic has_fixed = 1'b0,
                                                gcfd_pkg::rsp_type fixed_rsp = '0);
      stim_row_type row;
      row.kind      = ROW_REQUEST;
      row.reg_index = gcfd_pkg::CSR_COMPONENT_GAIN;
      row.reg_value = '0;
      row.req.current_x      = x;
      row.req.current_y      = y;
      row.req.bridge_enabled = en;
      row.has_fixed = has_fixed;
      row.fixed_rsp = fixed_rsp;
      return row;
   endfunction

   // Presents one request and holds it until accepted, then maybe idles.
   task automatic send_request(gcfd_pkg::req_type r, logic has_fixed = 1'b0,
                               gcfd_pkg::rsp_type fixed_rsp = '0);
      gcfd_pkg::rsp_type want;
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      want = predict_tick(r);
      if (has_fixed) want = fixed_rsp;
      expected_rsp_q.push_back(want);
      gap = sender_quiet ? 0 : gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every outstanding response has arrived and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(gcfd_pkg::csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         gcfd_pkg::CSR_COMPONENT_GAIN:  comp_gain_r = val;
         gcfd_pkg::CSR_MAGNITUDE_GAIN:  mag_gain_r  = val;
         gcfd_pkg::CSR_FAULT_THRESHOLD: fault_thr_r = val;
         gcfd_pkg::CSR_ALARM_THRESHOLD: alarm_thr_r = val;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1;
         3, 4, 5: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(2000, 40000));
      endcase
   endfunction

   function automatic logic [15:0] pick_threshold();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 46000));
      endcase
   endfunction

   // Mostly steady or slowly jittering samples so the filters settle and the flags move;
   // the rest is single random samples and bridge-off requests.
   task automatic run_random_phase(int unsigned count);
      int unsigned      sent;
      int unsigned      seg_len;
      int unsigned      kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      gcfd_pkg::req_type r;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 19);
         x = rand_sample();
         y = rand_sample();
         if (kind < 4) begin
            r.current_x      = x;
            r.current_y      = y;
            r.bridge_enabled = (kind != 0);
            send_request(r);
            sent++;
         end else begin
            seg_len = $urandom_range(4, 40);
            repeat (seg_len) begin
               r.current_x      = x;
               r.current_y      = y;
               r.bridge_enabled = 1'b1;
               if ($urandom_range(0, 3) == 0) begin
                  r.current_x = x + 16'($urandom_range(0, 15)) - 16'd8;
                  r.current_y = y + 16'($urandom_range(0, 15)) - 16'd8;
               end
               send_request(r);
               sent++;
            end
         end
      end
   endtask

   // Receiver: open windows of random length broken by random stalls.
   initial begin
      int unsigned open_len;
      int unsigned stall_len;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         open_len = $urandom_range(1, 12);
         repeat (open_len) @(posedge clock);
         if (!receiver_quiet) begin
            stall_len = gap_len();
            if (stall_len != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall_len) @(posedge clock);
            end
         end
      end
   end

   // Response checker: each accepted response against the oldest expectation.
   always @(posedge clock) begin
      gcfd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            note_error("response with no request outstanding");
         end else begin
            want = expected_rsp_q.pop_front();
            compare_field("magnitude_raw", rsp_data.magnitude_raw, want.magnitude_raw);
            compare_field("magnitude_filtered", rsp_data.magnitude_filtered,
                          want.magnitude_filtered);
            compare_field("fault", rsp_data.fault, want.fault);
            compare_field("alarm", rsp_data.alarm, want.alarm);
         end
      end
   end

   // Main sequence: reset, directed table, random phases, final check.
   initial begin
      int unsigned  waited;
      stim_row_type row;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = gcfd_pkg::CSR_COMPONENT_GAIN;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset gains and thresholds: bridge off gives zeros, zero input gives zeros.
      directed_rows.push_back(request_row(16'sh7FFF, 16'sh8000, 1'b0, 1'b1, ZERO_RSP));
      directed_rows.push_back(request_row(16'sh0000, 16'sh0000, 1'b1, 1'b1, ZERO_RSP));
      directed_rows.push_back(request_row(16'sh7FFF, 16'sh7FFF, 1'b1));
      directed_rows.push_back(request_row(16'sh8000, 16'sh8000, 1'b1));
      directed_rows.push_back(request_row(16'sh8000, 16'sh7FFF, 1'b1));
      directed_rows.push_back(request_row(16'sh0000, 16'sh0000, 1'b0, 1'b1, ZERO_RSP));
      // Largest gains: the filters jump almost all the way in one step.
      directed_rows.push_back(write_row(gcfd_pkg::CSR_COMPONENT_GAIN, 16'hFFFF));
      directed_rows.push_back(write_row(gcfd_pkg::CSR_MAGNITUDE_GAIN, 16'hFFFF));
      directed_rows.push_back(request_row(16'sh8000, 16'sh8000, 1'b1));
      directed_rows.push_back(request_row(16'sh8000, 16'sh8000, 1'b1));
      directed_rows.push_back(request_row(16'sh7FFF, 16'sh0000, 1'b1));
      directed_rows.push_back(request_row(16'sh0000, 16'sh8000, 1'b1));
      // Zero thresholds: bridge off still suppresses the flags, bridge on raises both.
      directed_rows.push_back(write_row(gcfd_pkg::CSR_FAULT_THRESHOLD, 16'd0));
      directed_rows.push_back(write_row(gcfd_pkg::CSR_ALARM_THRESHOLD, 16'd0));
      directed_rows.push_back(request_row(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1, ZERO_RSP));
      directed_rows.push_back(request_row(16'sh0000, 16'sh0000, 1'b1, 1'b1, FLAGS_RSP));
      // Mid thresholds: alarm first, then fault, and the fault drops when the input does.
      directed_rows.push_back(write_row(gcfd_pkg::CSR_FAULT_THRESHOLD, 16'd30000));
      directed_rows.push_back(write_row(gcfd_pkg::CSR_ALARM_THRESHOLD, 16'd20000));
      directed_rows.push_back(request_row(16'sh5000, 16'sh5000, 1'b1));
      directed_rows.push_back(request_row(16'sh7FFF, 16'sh7FFF, 1'b1));
      directed_rows.push_back(request_row(16'sh7FFF, 16'sh7FFF, 1'b1));
      directed_rows.push_back(request_row(16'sh0010, 16'shFFF0, 1'b1));
      // Zero gains hold the filters where they are.
      directed_rows.push_back(write_row(gcfd_pkg::CSR_COMPONENT_GAIN, 16'd0));
      directed_rows.push_back(request_row(16'sh7FFF, 16'sh8000, 1'b1));
      directed_rows.push_back(write_row(gcfd_pkg::CSR_MAGNITUDE_GAIN, 16'd0));
      directed_rows.push_back(request_row(16'shFFFF, 16'sh0001, 1'b1));
      // Smallest nonzero gains.
      directed_rows.push_back(write_row(gcfd_pkg::CSR_COMPONENT_GAIN, 16'd1));
      directed_rows.push_back(write_row(gcfd_pkg::CSR_MAGNITUDE_GAIN, 16'd1));
      directed_rows.push_back(request_row(16'sh8000, 16'sh7FFF, 1'b1));
      directed_rows.push_back(request_row(16'sh0001, 16'shFFFF, 1'b1));
      directed_rows.push_back(request_row(16'sh1234, 16'shEDCB, 1'b0, 1'b1, ZERO_RSP));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            drain();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            send_request(row.req, row.has_fixed, row.fixed_rsp);
         end
      end

      // Random phases, each under fresh register settings and idling habits.
      for (int unsigned p = 0; p < PHASES; p++) begin
         drain();
         write_reg(gcfd_pkg::CSR_COMPONENT_GAIN, pick_gain());
         write_reg(gcfd_pkg::CSR_MAGNITUDE_GAIN, pick_gain());
         write_reg(gcfd_pkg::CSR_FAULT_THRESHOLD, pick_threshold());
         write_reg(gcfd_pkg::CSR_ALARM_THRESHOLD, pick_threshold());
         sender_quiet   = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         run_random_phase(PHASE_ITEMS);
      end

      // Let the last responses arrive, then look for any left behind.
      req_valid <= 1'b0;
      waited = 0;
      while (expected_rsp_q.size() != 0 && waited < FINAL_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         note_error($sformatf("%0d responses never arrived", expected_rsp_q.size()));

      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
